// ----- hw/rtl/dmsr_pkg.sv -----
// Shared types and codes for the dual motor slew ramp drive.
package dmsr_pkg;

	// Operation codes carried on the input side band
	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	// Motor direction codes
	localparam logic [1:0] DIR_RELEASE  = 2'd0;
	localparam logic [1:0] DIR_FORWARD  = 2'd1;
	localparam logic [1:0] DIR_BACKWARD = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_SLEW_STEP    = 3'd0;
	localparam logic [2:0] CFG_MAX_SPEED    = 3'd1;
	localparam logic [2:0] CFG_MIN_SPEED    = 3'd2;
	localparam logic [2:0] CFG_INVERT_LEFT  = 3'd3;
	localparam logic [2:0] CFG_INVERT_RIGHT = 3'd4;

	// Result word layout widths
	localparam int unsigned RESULT_BITS = 40;

	// Control handed to each lane along with an accepted word
	typedef struct packed {
		logic       accept;
		logic       op_set;
		logic       op_tick;
		logic       op_stop;
		logic [7:0] slew_step;
		logic [7:0] max_speed;
	} lane_ctrl_t;

	// Drive settings used by the merging stage
	typedef struct packed {
		logic [7:0] min_speed;
		logic       invert_left;
		logic       invert_right;
	} drive_cfg_t;

endpackage

// ----- hw/rtl/dmsr_lane.sv -----
// One motor lane: goal register, level register, request clamp and slew ramp.
module dmsr_lane (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dmsr_pkg::lane_ctrl_t    ctrl,
	input  logic signed [15:0]      request,
	output logic signed [8:0]       level_next
);

	logic signed [8:0]  goal_q;
	logic signed [8:0]  level_q;
	logic signed [8:0]  goal_clamped;
	logic signed [8:0]  level_ramped;
	logic signed [16:0] req_wide;
	logic signed [16:0] max_pos;
	logic signed [16:0] max_neg;
	logic signed [10:0] level_wide;
	logic signed [10:0] goal_wide;
	logic signed [10:0] step_wide;
	logic signed [10:0] up_sum;
	logic signed [10:0] down_sum;

	// Saturate the request to plus or minus the maximum speed.
	always_comb begin
		req_wide = {request[15], request};
		max_pos  = $signed({9'd0, ctrl.max_speed});
		max_neg  = -max_pos;
		if (req_wide > max_pos) begin
			goal_clamped = $signed({1'b0, ctrl.max_speed});
		end else if (req_wide < max_neg) begin
			goal_clamped = -$signed({1'b0, ctrl.max_speed});
		end else begin
			goal_clamped = request[8:0];
		end
	end

	// Move towards the goal by at most one step, stopping at the goal.
	always_comb begin
		level_wide = {{2{level_q[8]}}, level_q};
		goal_wide  = {{2{goal_q[8]}}, goal_q};
		step_wide  = $signed({3'd0, ctrl.slew_step});
		up_sum     = level_wide + step_wide;
		down_sum   = level_wide - step_wide;
		if (goal_wide > level_wide) begin
			level_ramped = (up_sum > goal_wide) ? goal_q : up_sum[8:0];
		end else if (goal_wide < level_wide) begin
			level_ramped = (down_sum < goal_wide) ? goal_q : down_sum[8:0];
		end else begin
			level_ramped = level_q;
		end
	end

	always_comb begin
		if (ctrl.op_tick) begin
			level_next = level_ramped;
		end else if (ctrl.op_stop) begin
			level_next = '0;
		end else begin
			level_next = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q  <= '0;
			level_q <= '0;
		end else if (ctrl.accept) begin
			level_q <= level_next;
			if (ctrl.op_set) begin
				goal_q <= goal_clamped;
			end else if (ctrl.op_stop) begin
				goal_q <= '0;
			end
		end
	end

endmodule

// ----- hw/rtl/dmsr_merge.sv -----
// Merging stage: turns both lane levels into duty and direction and packs the result word.
module dmsr_merge (
	input  dmsr_pkg::drive_cfg_t                 cfg,
	input  logic signed [8:0]                    left_level,
	input  logic signed [8:0]                    right_level,
	output logic [dmsr_pkg::RESULT_BITS-1:0]     result
);

	typedef struct packed {
		logic [7:0] duty;
		logic [1:0] dir;
	} drive_t;

	drive_t left_drv;
	drive_t right_drv;

	function automatic drive_t drive_motor(input logic signed [8:0] level, input logic inv,
			input logic [7:0] min_speed);
		drive_t            d;
		logic signed [9:0] v;
		logic signed [9:0] mag;
		v   = inv ? -{level[8], level} : {level[8], level};
		mag = (v < 0) ? -v : v;
		if (v == 10'sd0) begin
			d.duty = 8'd0;
			d.dir  = dmsr_pkg::DIR_RELEASE;
		end else begin
			// Magnitude never exceeds 255 since levels stay within range.
			d.duty = (mag[7:0] < min_speed) ? min_speed : mag[7:0];
			d.dir  = (v > 0) ? dmsr_pkg::DIR_FORWARD : dmsr_pkg::DIR_BACKWARD;
		end
		return d;
	endfunction

	always_comb begin
		left_drv  = drive_motor(left_level, cfg.invert_left, cfg.min_speed);
		right_drv = drive_motor(right_level, cfg.invert_right, cfg.min_speed);
		result    = {2'b00, right_level, left_level, right_drv.dir, right_drv.duty,
			left_drv.dir, left_drv.duty};
	end

endmodule

// ----- hw/rtl/dual_motor_slew_ramp_drive.sv -----
// Top level of the dual motor slew ramp drive: lanes, merging stage and output buffer.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+-----------------------------------------
//  s_axis   | in        | s_tvalid / s_tready      | s_tuser opcode, s_tdata requests
//  m_axis   | out       | m_tvalid / m_tready      | m_tdata duty, direction and levels
//  config   | in        | cfg_wr_en                | cfg_index, cfg_data
//
// One word is taken every cycle while s_tready is high; its result is ready in the output buffer on the next cycle.
// The two lane registers update at the edge that accepts a word, so a word can follow at once.
// A two-word output buffer lets the input keep taking words while a result waits downstream;
// s_tready drops only when both buffer entries hold results that have not been taken.
// Reset clears the goals and levels, empties the buffer and sets the configuration to its defaults.
module dual_motor_slew_ramp_drive (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] left_request, [31:16] right_request
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] left_duty, [9:8] left_dir, [17:10] right_duty, [19:18] right_dir,
	// [28:20] left_now, [37:29] right_now, [39:38] zero
	output logic [39:0] m_tdata,
	// Configuration write port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] slew_step_q;
	logic [7:0] max_speed_q;
	logic [7:0] min_speed_q;
	logic       invert_left_q;
	logic       invert_right_q;

	logic                     accept;
	dmsr_pkg::lane_ctrl_t     lane_ctrl;
	dmsr_pkg::drive_cfg_t     drive_cfg;
	logic signed [8:0]        left_next;
	logic signed [8:0]        right_next;
	logic [dmsr_pkg::RESULT_BITS-1:0] result;

	// Output buffer: two entries, written at accept, read when downstream takes a word.
	logic [dmsr_pkg::RESULT_BITS-1:0] buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	// Configuration registers; writes must arrive only while the block is idle (the block does not enforce this).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_step_q    <= 8'd8;
			max_speed_q    <= 8'd255;
			min_speed_q    <= 8'd0;
			invert_left_q  <= 1'b0;
			invert_right_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dmsr_pkg::CFG_SLEW_STEP:    slew_step_q    <= cfg_data;
				dmsr_pkg::CFG_MAX_SPEED:    max_speed_q    <= cfg_data;
				dmsr_pkg::CFG_MIN_SPEED:    min_speed_q    <= cfg_data;
				dmsr_pkg::CFG_INVERT_LEFT:  invert_left_q  <= cfg_data[0];
				dmsr_pkg::CFG_INVERT_RIGHT: invert_right_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready = (count_q != 2'd2);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (count_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = buf_q[rd_ptr_q];

	// Both lanes see the same operation; an unused opcode leaves goals and levels as they are but still buffers a result.
	always_comb begin
		lane_ctrl.accept    = accept;
		lane_ctrl.op_set    = (s_tuser == dmsr_pkg::OP_SET);
		lane_ctrl.op_tick   = (s_tuser == dmsr_pkg::OP_TICK);
		lane_ctrl.op_stop   = (s_tuser == dmsr_pkg::OP_STOP);
		lane_ctrl.slew_step = slew_step_q;
		lane_ctrl.max_speed = max_speed_q;
		drive_cfg.min_speed    = min_speed_q;
		drive_cfg.invert_left  = invert_left_q;
		drive_cfg.invert_right = invert_right_q;
	end

	dmsr_lane u_left_lane (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (lane_ctrl),
		.request    ($signed(s_tdata[15:0])),
		.level_next (left_next)
	);

	dmsr_lane u_right_lane (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (lane_ctrl),
		.request    ($signed(s_tdata[31:16])),
		.level_next (right_next)
	);

	dmsr_merge u_merge (
		.cfg         (drive_cfg),
		.left_level  (left_next),
		.right_level (right_next),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({accept, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q[wr_ptr_q] <= result;
		end
	end

endmodule
